[hdl/contiguous_cell_allocator_core_macros.svh]
// assertion macros for the contiguous cell allocator
`ifndef CONTIGUOUS_CELL_ALLOCATOR_CORE_MACROS_SVH
`define CONTIGUOUS_CELL_ALLOCATOR_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CCA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cca assertion failed");

// consequent checked in the cycle after the antecedent
`define CCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cca assertion failed");

`endif

[hdl/cca_pkg.sv]
// shared constants, codes and types of the contiguous cell allocator
package cca_pkg;

   localparam int CELL_COUNT_DEF = 1024;
   localparam int TAG_BITS_DEF   = 16;

   localparam int TAG_W    = 16;
   localparam int SIZE_W   = 11;
   localparam int STATUS_W = 2;
   localparam int START_W  = 10;
   localparam int FREED_W  = 11;
   localparam int POLICY_W = 2;

   localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOC   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd3;

   // control from the sequencer to the run tracker
   typedef struct packed {
      logic start;
      logic step;
      logic is_free;
   } run_ctl_type;

endpackage

[hdl/cca_cell_mem.sv]
// cell owner store: one write port, one registered read port
module cca_cell_mem
   import cca_pkg::*;
#(
   parameter int DEPTH = CELL_COUNT_DEF,
   parameter int WIDTH = TAG_BITS_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/cca_run_tracker.sv]
// free run tracker: measures runs one cell a step and keeps the policy's pick
module cca_run_tracker
   import cca_pkg::*;
#(
   parameter int CELL_COUNT = CELL_COUNT_DEF,
   localparam int AW = $clog2(CELL_COUNT),
   localparam int CW = $clog2(CELL_COUNT + 1),
   localparam int LW = (CW > SIZE_W) ? CW : SIZE_W
) (
   input  logic                clock,
   input  logic                reset,
   input  run_ctl_type         ctl,
   input  logic [AW-1:0]       idx,
   input  logic [SIZE_W-1:0]   size,
   input  logic [POLICY_W-1:0] policy,
   output logic                have,
   output logic [AW-1:0]       pick_start
);

   logic          have_ff, have_in;
   logic [CW-1:0] run_len_ff, run_len_in;
   logic [AW-1:0] run_start_ff, run_start_in;
   logic [CW-1:0] pick_len_ff, pick_len_in;
   logic [AW-1:0] pick_start_ff, pick_start_in;
   logic          fits;
   logic          take;

   assign fits = (LW'(run_len_ff) >= LW'(size)) && (run_len_ff != '0);

   always_comb begin
      take = !have_ff;
      if (policy == FIT_BEST && run_len_ff < pick_len_ff) begin
         take = 1'b1;
      end
      if (policy == FIT_WORST && run_len_ff > pick_len_ff) begin
         take = 1'b1;
      end
   end

   always_comb begin
      have_in       = have_ff;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      pick_len_in   = pick_len_ff;
      pick_start_in = pick_start_ff;
      if (ctl.start) begin
         have_in       = 1'b0;
         run_len_in    = '0;
         pick_len_in   = '0;
         pick_start_in = '0;
      end else if (ctl.step) begin
         if (ctl.is_free) begin
            if (run_len_ff == '0) begin
               run_start_in = idx;
            end
            run_len_in = run_len_ff + CW'(1);
         end else begin
            // a run just ended
            if (fits && take) begin
               have_in       = 1'b1;
               pick_len_in   = run_len_ff;
               pick_start_in = run_start_ff;
            end
            run_len_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff    <= 1'b0;
         run_len_ff <= '0;
      end else begin
         have_ff    <= have_in;
         run_len_ff <= run_len_in;
      end
   end

   always_ff @(posedge clock) begin
      run_start_ff  <= run_start_in;
      pick_len_ff   <= pick_len_in;
      pick_start_ff <= pick_start_in;
   end

   assign have       = have_ff;
   assign pick_start = pick_start_ff;

endmodule

[hdl/contiguous_cell_allocator_core.sv]
// Contiguous cell allocator. The cell store sits in a single-port-read memory
// that is walked one cell per cycle by a small sequencer. After reset the store
// is swept clear, and no item is accepted during the sweep (the policy register
// can be written at any time). An allocate scans every cell plus the end-of-store
// boundary, then writes the tag into each claimed cell, then posts the result.
// A clear scans every cell and zeroes each cell that holds its tag. A zero
// size allocate or a clear of tag zero goes straight to posting the result.
// One item is in flight at a time; the next item is taken once the result of
// the previous one is in the output register.
`include "contiguous_cell_allocator_core_macros.svh"

module contiguous_cell_allocator_core
   import cca_pkg::*;
#(
   parameter int CELL_COUNT = CELL_COUNT_DEF,
   parameter int TAG_BITS   = TAG_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [TAG_W-1:0]    req_owner_tag,
   input  logic [SIZE_W-1:0]   req_request_size,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [START_W-1:0]  rsp_start_cell,
   output logic [FREED_W-1:0]  rsp_freed_count,
   input  logic                csr_wr_en,
   input  logic [POLICY_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(CELL_COUNT);
   localparam int CW = $clog2(CELL_COUNT + 1);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_PICK  = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_CLR   = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic                pend_last_ff, pend_last_in;
   logic [AW-1:0]       pend_idx_ff, pend_idx_in;
   logic                act_ff, act_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [CW-1:0]       freed_ff, freed_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [POLICY_W-1:0] policy_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [FREED_W-1:0]  rsp_freed_ff, rsp_freed_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [TAG_BITS-1:0] wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [TAG_BITS-1:0] rd_data;

   run_ctl_type         run_ctl;
   logic                have;
   logic [AW-1:0]       pick_start;
   logic [TAG_BITS-1:0] req_tag;

   assign req_tag = TAG_BITS'({{TAG_BITS{1'b0}}, req_owner_tag});

   cca_cell_mem #(
      .DEPTH (CELL_COUNT),
      .WIDTH (TAG_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cca_run_tracker #(
      .CELL_COUNT (CELL_COUNT)
   ) u_run (
      .clock      (clock),
      .reset      (reset),
      .ctl        (run_ctl),
      .idx        (pend_idx_ff),
      .size       (size_ff),
      .policy     (policy_ff),
      .have       (have),
      .pick_start (pick_start)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= FIT_FIRST;
      end else if (csr_wr_en) begin
         policy_ff <= csr_wr_data;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      pend_last_in  = 1'b0;
      pend_idx_in   = pend_idx_ff;
      act_in        = act_ff;
      tag_in        = tag_ff;
      size_in       = size_ff;
      freed_in      = freed_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_addr       = pend_idx_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      run_ctl       = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_freed_in  = rsp_freed_ff;

      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            idx_in  = idx_ff + CW'(1);
            if (idx_ff == CW'(CELL_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               tag_in   = req_tag;
               size_in  = req_request_size;
               idx_in   = '0;
               freed_in = '0;
               if (req_action == ACT_CLEAR) begin
                  res_status_in = ST_CLEARED;
                  state_in      = (req_tag == '0) ? S_RESP : S_CLR;
               end else if (req_request_size == '0) begin
                  res_status_in = ST_ZERO;
                  state_in      = S_RESP;
               end else begin
                  run_ctl.start = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // evaluate the cell read last cycle; the boundary past the end is never free
            if (pend_ff) begin
               run_ctl.step    = 1'b1;
               run_ctl.is_free = !pend_last_ff && (rd_data == '0);
            end
            if (pend_ff && pend_last_ff) begin
               state_in = S_PICK;
            end else if (idx_ff == CW'(CELL_COUNT)) begin
               pend_in      = 1'b1;
               pend_last_in = 1'b1;
            end else begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[AW-1:0];
               idx_in      = idx_ff + CW'(1);
            end
         end
         S_PICK: begin
            idx_in = '0;
            if (have) begin
               state_in = S_WRITE;
            end else begin
               res_status_in = ST_NOFIT;
               state_in      = S_RESP;
            end
         end
         S_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = pick_start + idx_ff[AW-1:0];
            wr_data = tag_ff;
            idx_in  = idx_ff + CW'(1);
            if (idx_ff + CW'(1) == CW'(size_ff)) begin
               res_status_in = ST_ALLOC;
               state_in      = S_RESP;
            end
         end
         S_CLR: begin
            if (pend_ff && rd_data == tag_ff) begin
               wr_en    = 1'b1;
               freed_in = freed_ff + CW'(1);
            end
            if (pend_ff && pend_last_ff) begin
               state_in = S_RESP;
            end else if (idx_ff != CW'(CELL_COUNT)) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_last_in = (idx_ff == CW'(CELL_COUNT - 1));
               pend_idx_in  = idx_ff[AW-1:0];
               idx_in       = idx_ff + CW'(1);
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = (res_status_ff == ST_ALLOC) ?
                               START_W'({{START_W{1'b0}}, pick_start}) : '0;
               rsp_freed_in  = (act_ff == ACT_CLEAR) ?
                               FREED_W'({{FREED_W{1'b0}}, freed_ff}) : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      act_ff        <= act_in;
      tag_ff        <= tag_in;
      size_ff       <= size_in;
      freed_ff      <= freed_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_start_cell  = rsp_start_ff;
   assign rsp_freed_count = rsp_freed_ff;

   // an accepted item always moves the sequencer out of idle
   `CCA_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != S_IDLE)
   // the run is only written once a fitting run was found
   `CCA_ASSERT_NOW(a_write_has_pick, clock, reset, state_ff == S_WRITE, have)
   // only an allocated item reports a start cell
   `CCA_ASSERT_NOW(a_start_alloc, clock, reset, rsp_valid_ff && rsp_start_ff != '0,
                   rsp_status_ff == ST_ALLOC)
   // only a clear reports freed cells
   `CCA_ASSERT_NOW(a_freed_clear, clock, reset, rsp_valid_ff && rsp_freed_ff != '0,
                   rsp_status_ff == ST_CLEARED)

endmodule
